### rtl/core/mmrr_pkg.sv
// Package with shared constants, codes and control types of the missing-row removal block.
package mmrr_pkg;

  localparam int unsigned MAX_ROWS = 256;
  localparam int unsigned MAX_COLS = 16;

  localparam int unsigned ROW_W   = $clog2(MAX_ROWS);
  localparam int unsigned COL_W   = $clog2(MAX_COLS);
  localparam int unsigned DEPTH   = MAX_ROWS * MAX_COLS;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned ROWS_W  = 9;
  localparam int unsigned COLS_W  = 5;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned CFG_W   = 9;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned OUT_TDATA_W = 80;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEM_IS_INT  = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_EMIT,
    ST_SEEK,
    ST_SCAN,
    ST_RESP_ZERO,
    ST_RESP_EMPTY,
    ST_RESP_DATA
  } ctl_state_e;

  typedef enum logic [1:0] {
    OUT_ZERO,
    OUT_EMPTY,
    OUT_DATA
  } out_kind_e;

  typedef struct packed {
    logic      load_en;
    logic      load_restart;
    logic      fetch_en;
    logic      scan_en;
    logic      out_en;
    out_kind_e out_kind;
  } ctl_cmd_t;

  typedef struct packed {
    logic load_last;
    logic cur_kept;
    logic at_end;
    logic kept_zero;
    logic slot_free;
    logic cfg_hit;
  } ctl_status_t;

endpackage

### rtl/core/mmrr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mmrr_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/mmrr_ctrl.sv
// Controller state machine that sequences loads, row scans and result delivery.
module mmrr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_opcode_i,
  output logic                 in_ready_o,
  input  mmrr_pkg::ctl_status_t status_i,
  output mmrr_pkg::ctl_cmd_t    cmd_o
);
  import mmrr_pkg::*;

  ctl_state_e state_q, state_d;
  logic       in_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_acc = in_valid_i && in_ready_o;

  always_comb begin
    state_d          = state_q;
    in_ready_o       = 1'b0;
    cmd_o            = '0;
    cmd_o.out_kind   = OUT_ZERO;
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_acc) begin
          if (in_opcode_i == OP_LOAD) begin
            cmd_o.load_en = 1'b1;
            state_d = status_i.load_last ? ST_SEEK : ST_LOAD;
          end else begin
            state_d = ST_RESP_ZERO;
          end
        end
      end
      ST_EMIT: begin
        in_ready_o         = 1'b1;
        cmd_o.load_restart = 1'b1;
        if (in_acc) begin
          if (in_opcode_i == OP_LOAD) begin
            cmd_o.load_en = 1'b1;
            state_d = status_i.load_last ? ST_SEEK : ST_LOAD;
          end else if (status_i.kept_zero) begin
            state_d = ST_RESP_EMPTY;
          end else begin
            cmd_o.fetch_en = 1'b1;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SEEK: begin
        if (status_i.kept_zero || status_i.at_end || status_i.cur_kept) begin
          state_d = ST_EMIT;
        end else begin
          cmd_o.scan_en = 1'b1;
        end
      end
      ST_SCAN: begin
        if (status_i.at_end || status_i.cur_kept) begin
          state_d = ST_RESP_DATA;
        end else begin
          cmd_o.scan_en = 1'b1;
        end
      end
      ST_RESP_ZERO: begin
        if (status_i.slot_free) begin
          cmd_o.out_en   = 1'b1;
          cmd_o.out_kind = OUT_ZERO;
          state_d = ST_LOAD;
        end
      end
      ST_RESP_EMPTY: begin
        if (status_i.slot_free) begin
          cmd_o.out_en   = 1'b1;
          cmd_o.out_kind = OUT_EMPTY;
          state_d = ST_LOAD;
        end
      end
      ST_RESP_DATA: begin
        if (status_i.slot_free) begin
          cmd_o.out_en   = 1'b1;
          cmd_o.out_kind = OUT_DATA;
          state_d = status_i.at_end ? ST_LOAD : ST_EMIT;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
    // Configuration writes must arrive only while idle (not enforced by the block); they abandon any load or emission.
    if (status_i.cfg_hit) begin
      state_d = ST_LOAD;
    end
  end

endmodule

### rtl/core/mmrr_datapath.sv
// Datapath with configuration, element store, drop flags, pointers and output register.
module mmrr_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mmrr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mmrr_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic [mmrr_pkg::VALUE_W-1:0]        in_value_i,
  input  mmrr_pkg::ctl_cmd_t                  cmd_i,
  output mmrr_pkg::ctl_status_t               status_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [mmrr_pkg::VALUE_W-1:0]        out_value_o,
  output logic                                out_flag_o,
  output logic                                out_last_o,
  output logic [mmrr_pkg::ROWS_W-1:0]         out_kept_o
);
  import mmrr_pkg::*;

  // Configuration registers.
  logic [ROWS_W-1:0] row_count_q;
  logic [COLS_W-1:0] column_count_q;
  logic              elem_int_q;
  logic              cfg_hit;

  logic [ROW_W-1:0]  rows_m1;
  logic [COL_W-1:0]  cols_m1;
  logic [ROWS_W-1:0] rows_used;

  // Load side.
  logic [ADDR_W-1:0]   ld_addr_q;
  logic [ROW_W-1:0]    ld_row_q;
  logic [COL_W-1:0]    ld_col_q;
  logic                ld_clear;
  logic [ADDR_W-1:0]   base_addr;
  logic [ROW_W-1:0]    base_row;
  logic [COL_W-1:0]    base_col;
  logic                load_last;
  logic                miss;
  logic [VALUE_W-1:0]  store_value;

  logic [MAX_ROWS-1:0] drop_q, drop_d, drop_base;
  logic [ROWS_W-1:0]   drop_cnt_q, drop_cnt_d;
  logic [ROWS_W-1:0]   kept_q;

  // Read side.
  logic [ADDR_W-1:0]   rd_addr_q;
  logic [ROW_W-1:0]    rd_row_q;
  logic [COL_W-1:0]    rd_col_q;
  logic                at_end_q;
  logic                step;

  logic [VALUE_W-1:0]  ram_rdata;
  logic                m_valid_q;
  logic                slot_free;

  assign cfg_hit = cfg_we_i && ((cfg_index_i == CFG_ROW_COUNT) ||
                                (cfg_index_i == CFG_COLUMN_COUNT) ||
                                (cfg_index_i == CFG_ELEM_IS_INT));

  // Clamp the size registers to the supported range.
  always_comb begin
    if (row_count_q == '0) begin
      rows_m1 = '0;
    end else if (row_count_q > ROWS_W'(MAX_ROWS)) begin
      rows_m1 = ROW_W'(MAX_ROWS - 1);
    end else begin
      rows_m1 = ROW_W'(row_count_q - ROWS_W'(1));
    end
    if (column_count_q == '0) begin
      cols_m1 = '0;
    end else if (column_count_q > COLS_W'(MAX_COLS)) begin
      cols_m1 = COL_W'(MAX_COLS - 1);
    end else begin
      cols_m1 = COL_W'(column_count_q - COLS_W'(1));
    end
  end

  assign rows_used = ROWS_W'(rows_m1) + ROWS_W'(1);

  // A load at the start of a matrix, or one during emission, starts over.
  assign ld_clear  = cmd_i.load_restart || (ld_addr_q == '0);
  assign base_addr = ld_clear ? '0 : ld_addr_q;
  assign base_row  = ld_clear ? '0 : ld_row_q;
  assign base_col  = ld_clear ? '0 : ld_col_q;
  assign load_last = (base_row == rows_m1) && (base_col == cols_m1);

  always_comb begin
    if (elem_int_q) begin
      miss = (in_value_i[31:0] == 32'h8000_0000);
      store_value = {32'b0, in_value_i[31:0]};
    end else begin
      miss = (in_value_i[62:52] == 11'h7FF) && (in_value_i[51:0] != '0);
      store_value = in_value_i;
    end
  end

  always_comb begin
    drop_base = ld_clear ? '0 : drop_q;
    drop_d    = drop_base;
    drop_cnt_d = ld_clear ? '0 : drop_cnt_q;
    if (miss) begin
      drop_d[base_row] = 1'b1;
      if (!drop_base[base_row]) begin
        drop_cnt_d = drop_cnt_d + ROWS_W'(1);
      end
    end
  end

  assign step = cmd_i.fetch_en || cmd_i.scan_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q    <= ROWS_W'(1);
      column_count_q <= COLS_W'(1);
      elem_int_q     <= 1'b0;
      ld_addr_q      <= '0;
      ld_row_q       <= '0;
      ld_col_q       <= '0;
      drop_q         <= '0;
      drop_cnt_q     <= '0;
      kept_q         <= '0;
      rd_addr_q      <= '0;
      rd_row_q       <= '0;
      rd_col_q       <= '0;
      at_end_q       <= 1'b0;
      m_valid_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_ROW_COUNT:    row_count_q    <= cfg_wdata_i;
          CFG_COLUMN_COUNT: column_count_q <= cfg_wdata_i[COLS_W-1:0];
          CFG_ELEM_IS_INT:  elem_int_q     <= cfg_wdata_i[0];
          default: ;
        endcase
      end

      if (cfg_hit) begin
        ld_addr_q <= '0;
        ld_row_q  <= '0;
        ld_col_q  <= '0;
      end else if (cmd_i.load_en) begin
        drop_q     <= drop_d;
        drop_cnt_q <= drop_cnt_d;
        if (load_last) begin
          ld_addr_q <= '0;
          ld_row_q  <= '0;
          ld_col_q  <= '0;
          kept_q    <= rows_used - drop_cnt_d;
          rd_addr_q <= '0;
          rd_row_q  <= '0;
          rd_col_q  <= '0;
          at_end_q  <= 1'b0;
        end else begin
          ld_addr_q <= base_addr + ADDR_W'(1);
          if (base_row == rows_m1) begin
            ld_row_q <= '0;
            ld_col_q <= base_col + COL_W'(1);
          end else begin
            ld_row_q <= base_row + ROW_W'(1);
            ld_col_q <= base_col;
          end
        end
      end

      // The read pointer walks the store linearly, one element a cycle while fetching or scanning.
      if (step) begin
        rd_addr_q <= rd_addr_q + ADDR_W'(1);
        if (rd_row_q == rows_m1) begin
          rd_row_q <= '0;
          if (rd_col_q == cols_m1) begin
            at_end_q <= 1'b1;
          end else begin
            rd_col_q <= rd_col_q + COL_W'(1);
          end
        end else begin
          rd_row_q <= rd_row_q + ROW_W'(1);
        end
      end

      if (cmd_i.out_en) begin
        m_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  mmrr_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_en),
    .waddr_i (base_addr),
    .wdata_i (store_value),
    .re_i    (cmd_i.fetch_en),
    .raddr_i (rd_addr_q),
    .rdata_o (ram_rdata)
  );

  assign slot_free = !m_valid_q || out_ready_i;

  // Output register; payload needs no reset.
  logic [VALUE_W-1:0] out_value_q;
  logic               out_flag_q;
  logic               out_last_q;
  logic [ROWS_W-1:0]  out_kept_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_en) begin
      out_kept_q <= kept_q;
      case (cmd_i.out_kind)
        OUT_DATA: begin
          out_value_q <= ram_rdata;
          out_flag_q  <= 1'b1;
          out_last_q  <= at_end_q;
        end
        OUT_EMPTY: begin
          out_value_q <= '0;
          out_flag_q  <= 1'b0;
          out_last_q  <= 1'b1;
        end
        default: begin
          out_value_q <= '0;
          out_flag_q  <= 1'b0;
          out_last_q  <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid_o = m_valid_q;
  assign out_value_o = out_value_q;
  assign out_flag_o  = out_flag_q;
  assign out_last_o  = out_last_q;
  assign out_kept_o  = out_kept_q;

  assign status_o.load_last = load_last;
  assign status_o.cur_kept  = !drop_q[rd_row_q];
  assign status_o.at_end    = at_end_q;
  assign status_o.kept_zero = (kept_q == '0);
  assign status_o.slot_free = slot_free;
  assign status_o.cfg_hit   = cfg_hit;

endmodule

### rtl/core/matrix_missing_row_removal.sv
// Top level of the missing-row removal block: controller, datapath and stream ports.
//
// The input stream carries one request per transfer; tuser selects the kind. A load
// request writes tdata (the raw element bits, upper half cleared in integer mode)
// into the next column-major slot of a row_count x column_count matrix and marks its
// row dropped when the element is a NaN (double mode) or 0x80000000 (integer mode).
// A load gives no result. After the last element the block scans for the first kept
// row, one row per cycle, before it takes the next request. A read request in the
// emit phase returns the next element of the kept rows in column-major order, with
// tlast on the final one: the store is read, the linear walk skips dropped rows, and
// the result is registered in the output register before the next request is taken.
// With no kept row, the first read gives a result with the valid flag clear and tlast
// set; reads outside the emit phase give a zero value with the valid flag and tlast
// clear. Each waits for a free output slot. Every result carries the kept-row count.
// Results sit in an output register; while the receiver stalls, the block keeps
// accepting requests until a second result is due, then holds it until the slot
// frees. Reset returns all sizes to 1, double mode, the load phase, and clears the
// drop flags; the element store is not cleared. Configuration writes to a known
// register abandon any partial load or emission.
module matrix_missing_row_removal (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [mmrr_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [mmrr_pkg::CFG_W-1:0]            cfg_wdata_i,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // tdata: [63:0] element_value
  input  logic [mmrr_pkg::VALUE_W-1:0]          s_axis_tdata_i,
  // tuser: [0] opcode
  input  logic                                  s_axis_tuser_i,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // tdata: [63:0] out_value, [72:64] kept_rows, [79:73] zero
  output logic [mmrr_pkg::OUT_TDATA_W-1:0]      m_axis_tdata_o,
  // tuser: [0] out_valid
  output logic                                  m_axis_tuser_o,
  output logic                                  m_axis_tlast_o
);
  import mmrr_pkg::*;

  ctl_cmd_t           cmd;
  ctl_status_t        status;
  logic [VALUE_W-1:0] out_value;
  logic [ROWS_W-1:0]  out_kept;

  mmrr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_opcode_i (s_axis_tuser_i),
    .in_ready_o  (s_axis_tready_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mmrr_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_value_i  (s_axis_tdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_value_o (out_value),
    .out_flag_o  (m_axis_tuser_o),
    .out_last_o  (m_axis_tlast_o),
    .out_kept_o  (out_kept)
  );

  assign m_axis_tdata_o = {(OUT_TDATA_W - VALUE_W - ROWS_W)'(0), out_kept, out_value};

endmodule
